[rtl/ecs_pkg.sv]
// shared types and constants of the exponential chi-squared kernel
package ecs_pkg;

    // datapath widths
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned SUM_W     = VAL_W + 1;
    localparam int unsigned CHI_W     = 48;
    localparam int unsigned OUT_W     = 17;
    localparam int unsigned DIV_NUM_W = 56;
    localparam int unsigned DIV_DEN_W = 17;
    localparam int unsigned MUL_MC_W  = 33;
    localparam int unsigned MUL_MP_W  = 32;
    localparam int unsigned MUL_P_W   = MUL_MC_W + MUL_MP_W;
    localparam int unsigned LEN_W     = 6;

    // fixed-point constants
    localparam logic [MUL_MC_W-1:0] LOG2E_Q32 = 33'd6196328019;
    localparam logic [MUL_MC_W-1:0] LN2_Q32   = 33'd2977044472;
    localparam logic [33:0]         ONE_Q32   = 34'h1_0000_0000;
    localparam logic [CHI_W-1:0]    SUM_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [3:0]          N_TERMS   = 4'd12;
    localparam logic [6:0]          K_LIMIT   = 7'd17;

    // serial step counts of each operation
    localparam logic [LEN_W-1:0] LEN_SQ   = 6'd16;
    localparam logic [LEN_W-1:0] LEN_TERM = 6'd40;
    localparam logic [LEN_W-1:0] LEN_X    = 6'd56;
    localparam logic [LEN_W-1:0] LEN_Y    = 6'd21;
    localparam logic [LEN_W-1:0] LEN_R    = 6'd16;
    localparam logic [LEN_W-1:0] LEN_TM   = 6'd32;
    localparam logic [LEN_W-1:0] LEN_TN   = 6'd33;

    // start request to a serial unit
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_unit_ctl;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_W,
        ST_TD,
        ST_TD_W,
        ST_XD,
        ST_XD_W,
        ST_YM,
        ST_YM_W,
        ST_RM,
        ST_RM_W,
        ST_TM,
        ST_TM_W,
        ST_TN,
        ST_TN_W,
        ST_OUT
    } t_state;

endpackage

[rtl/exp_chi_squared_kernel_core.sv]
// top level: exponential chi-squared kernel over streamed histogram pairs
//
// Input stream: one request per element pair, tdata = {b_value, a_value},
// tlast marks the final pair of the two vectors. Output stream: one request
// per vector, carrying exp(-sum/width) in unsigned Q0.16 (65536 is one).
// Config channel: i_cfg_data writes kernel_width (unsigned Q8.8), always ready.
// Each pair runs through a serial multiplier (square of the difference) and
// a radix-2 divider, which is skipped when a + b is zero; a new pair is taken
// only once those two serial units are done with the one before.
// A last pair then adds a division by the width, two short products and
// twelve series terms (each a product and a division) before tvalid rises;
// the remaining steps are skipped when the kernel underflows to zero.
// One pair is worked on at a time; s_axis_tready is high only between pairs.
// The result sits in an output register, so the next vector starts while it
// waits; if the receiver still holds an old result, the sequencer waits.
// Reset clears the running sum, sets the width to 1.0 and empties the output.
module exp_chi_squared_kernel_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // a_value[15:0], b_value[31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // kernel_value[16:0], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // kernel_width[15:0]
);
    import ecs_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [VAL_W-1:0]     r_width;
    logic [VAL_W-1:0]     r_diff;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_last;
    logic [CHI_W-1:0]     r_chi;
    logic [4:0]           r_k;
    logic [15:0]          r_f;
    logic                 r_zero;
    logic [MUL_MP_W-1:0]  r_r;
    logic [32:0]          r_term;
    logic [33:0]          r_acc;
    logic [3:0]           r_n;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_unit_ctl            w_mul_ctl;
    logic [MUL_MC_W-1:0]  w_mul_mc;
    logic [MUL_MP_W-1:0]  w_mul_mp;
    logic [MUL_P_W-1:0]   w_mul_prod;
    logic                 w_mul_done;
    t_unit_ctl            w_div_ctl;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic [DIV_NUM_W-1:0] w_div_quo;
    logic                 w_div_done;

    logic [VAL_W-1:0]     w_a;
    logic [VAL_W-1:0]     w_b;
    logic [VAL_W-1:0]     w_diff_in;
    logic [SUM_W-1:0]     w_sum_in;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic [CHI_W:0]       w_chi_add;
    logic                 w_x_big;
    logic [54:0]          w_y_sum;
    logic [6:0]           w_k;
    logic                 w_k_big;
    logic [47:0]          w_r_sum;
    logic [32:0]          w_t;
    logic [VAL_W-1:0]     w_width;
    logic [5:0]           w_shift;
    logic [34:0]          w_rnd;
    logic [34:0]          w_shr;
    logic [OUT_W-1:0]     w_result;

    // serial units
    ecs_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_mul_mc),
        .i_mplier (w_mul_mp),
        .o_prod   (w_mul_prod),
        .o_done   (w_mul_done)
    );

    ecs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    // handshakes
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_data};

    // input pair arithmetic
    always_comb begin
        w_a       = s_axis_tdata[15:0];
        w_b       = s_axis_tdata[31:16];
        w_diff_in = (w_a >= w_b) ? (w_a - w_b) : (w_b - w_a);
        w_sum_in  = {1'b0, w_a} + {1'b0, w_b};
    end

    // result unpacking of the serial units
    always_comb begin
        w_chi_add = {1'b0, r_chi} + {9'b0, w_div_quo[39:0]};
        w_x_big   = |w_div_quo[DIV_NUM_W-1:21];
        w_y_sum   = {1'b0, w_mul_prod[53:0]} + 55'h8000_0000;
        w_k       = w_y_sum[54:48];
        w_k_big   = w_k >= K_LIMIT;
        w_r_sum   = w_mul_prod[47:0] + 48'h8000;
        w_t       = w_mul_prod[MUL_P_W-1:32];
        w_width   = (r_width == '0) ? VAL_W'(1) : r_width;
    end

    // final rounding shift by 16 + k
    always_comb begin
        w_shift  = 6'd16 + {1'b0, r_k};
        w_rnd    = {1'b0, r_acc} + (35'd1 << (w_shift - 6'd1));
        w_shr    = w_rnd >> w_shift;
        w_result = r_zero ? '0 : w_shr[OUT_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_SQ;
            ST_SQ:   n_state = ST_SQ_W;
            ST_SQ_W: begin
                if (w_mul_done) begin
                    if (r_sum != '0) n_state = ST_TD;
                    else if (r_last) n_state = ST_XD;
                    else             n_state = ST_IDLE;
                end
            end
            ST_TD:   n_state = ST_TD_W;
            ST_TD_W: if (w_div_done) n_state = r_last ? ST_XD : ST_IDLE;
            ST_XD:   n_state = ST_XD_W;
            ST_XD_W: if (w_div_done) n_state = w_x_big ? ST_OUT : ST_YM;
            ST_YM:   n_state = ST_YM_W;
            ST_YM_W: if (w_mul_done) n_state = w_k_big ? ST_OUT : ST_RM;
            ST_RM:   n_state = ST_RM_W;
            ST_RM_W: if (w_mul_done) n_state = ST_TM;
            ST_TM:   n_state = ST_TM_W;
            ST_TM_W: if (w_mul_done) n_state = ST_TN;
            ST_TN:   n_state = ST_TN_W;
            ST_TN_W: if (w_div_done) n_state = (r_n == N_TERMS) ? ST_OUT : ST_TM;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // unit requests and operands
    always_comb begin
        w_mul_ctl = '0;
        w_mul_mc  = '0;
        w_mul_mp  = '0;
        w_div_ctl = '0;
        w_div_num = '0;
        w_div_den = '0;
        case (r_state)
            ST_SQ: begin
                w_mul_ctl = '{start: 1'b1, len: LEN_SQ};
                w_mul_mc  = {17'b0, r_diff};
                w_mul_mp  = {r_diff, 16'b0};
            end
            ST_TD: begin
                w_div_ctl = '{start: 1'b1, len: LEN_TERM};
                w_div_num = {w_mul_prod[31:0], 24'b0};
                w_div_den = r_sum;
            end
            ST_XD: begin
                w_div_ctl = '{start: 1'b1, len: LEN_X};
                w_div_num = {r_chi, 8'b0};
                w_div_den = {1'b0, w_width};
            end
            ST_YM: begin
                w_mul_ctl = '{start: 1'b1, len: LEN_Y};
                w_mul_mc  = LOG2E_Q32;
                w_mul_mp  = {w_div_quo[20:0], 11'b0};
            end
            ST_RM: begin
                w_mul_ctl = '{start: 1'b1, len: LEN_R};
                w_mul_mc  = LN2_Q32;
                w_mul_mp  = {r_f, 16'b0};
            end
            ST_TM: begin
                w_mul_ctl = '{start: 1'b1, len: LEN_TM};
                w_mul_mc  = r_term;
                w_mul_mp  = r_r;
            end
            ST_TN: begin
                w_div_ctl = '{start: 1'b1, len: LEN_TN};
                w_div_num = {w_t, 23'b0};
                w_div_den = {13'b0, r_n};
            end
            default: begin
                w_mul_ctl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= 16'd256;
            r_chi       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_width <= i_cfg_data;
            // saturating accumulate, cleared once the width division is done
            if (r_state == ST_TD_W && w_div_done) begin
                r_chi <= w_chi_add[CHI_W] ? SUM_MAX : w_chi_add[CHI_W-1:0];
            end else if (r_state == ST_XD_W && w_div_done) begin
                r_chi <= '0;
            end
            if (r_state == ST_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready)               r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_diff <= w_diff_in;
            r_sum  <= w_sum_in;
            r_last <= s_axis_tlast;
        end
        if (r_state == ST_XD_W && w_div_done) r_zero <= w_x_big;
        if (r_state == ST_YM_W && w_mul_done) begin
            r_zero <= w_k_big;
            r_k    <= w_k[4:0];
            r_f    <= w_y_sum[47:32];
        end
        // series start: term and sum at one
        if (r_state == ST_RM_W && w_mul_done) begin
            r_r    <= w_r_sum[47:16];
            r_n    <= 4'd1;
            r_term <= ONE_Q32[32:0];
            r_acc  <= ONE_Q32;
        end
        // alternate subtract and add of each series term
        if (r_state == ST_TN_W && w_div_done) begin
            r_term <= w_div_quo[32:0];
            r_acc  <= r_n[0] ? (r_acc - {1'b0, w_div_quo[32:0]})
                             : (r_acc + {1'b0, w_div_quo[32:0]});
            r_n    <= r_n + 4'd1;
        end
        if (r_state == ST_OUT && w_out_free) r_out_data <= w_result;
    end

`ifndef SYNTHESIS
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TN_W && w_div_done) |-> (r_n >= 4'd1 && r_n <= N_TERMS))
        else $error("series index out of range");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result shown outside the output step");
    a_chi_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_XD_W && w_div_done) |=> r_chi == '0)
        else $error("running sum not cleared after a vector");
    a_chi_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TD_W && w_div_done) |=> r_chi >= $past(r_chi))
        else $error("running sum decreased");
`endif

endmodule

[rtl/ecs_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module ecs_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ecs_pkg::t_unit_ctl              i_ctl,
    input  logic [ecs_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [ecs_pkg::DIV_DEN_W-1:0]   i_den,
    output logic [ecs_pkg::DIV_NUM_W-1:0]   o_quo,
    output logic                            o_done
);
    import ecs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [LEN_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_nq;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_sub;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // trial subtract of the shifted remainder
    always_comb begin
        w_rem_sh = {r_rem, r_nq[DIV_NUM_W-1]};
        w_ge     = w_rem_sh >= {1'b0, r_den};
        w_sub    = w_rem_sh - {1'b0, r_den};
        n_rem    = w_ge ? w_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
    end

    // step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and numerator/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_nq  <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_nq  <= {r_nq[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_nq;
    assign o_done = r_done;

endmodule

[rtl/ecs_mul.sv]
// shift-add multiplier, one multiplier bit per cycle from the top
module ecs_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ecs_pkg::t_unit_ctl             i_ctl,
    input  logic [ecs_pkg::MUL_MC_W-1:0]   i_mcand,
    input  logic [ecs_pkg::MUL_MP_W-1:0]   i_mplier,
    output logic [ecs_pkg::MUL_P_W-1:0]    o_prod,
    output logic                           o_done
);
    import ecs_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [LEN_W-1:0]    r_cnt;
    logic [MUL_P_W-1:0]  r_acc;
    logic [MUL_MP_W-1:0] r_mp;
    logic [MUL_MC_W-1:0] r_mc;
    logic [MUL_P_W-1:0]  n_acc;

    // double and add the multiplicand when the top bit is set
    always_comb begin
        n_acc = {r_acc[MUL_P_W-2:0], 1'b0}
              + (r_mp[MUL_MP_W-1] ? {{MUL_MP_W{1'b0}}, r_mc} : '0);
    end

    // step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // accumulator and multiplier shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
            r_mp  <= i_mplier;
            r_mc  <= i_mcand;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mp  <= {r_mp[MUL_MP_W-2:0], 1'b0};
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

[tb/kernel_checker.sv]
// checker: predicts kernel values from accepted pairs and compares results
`timescale 1ns / 1ps

module kernel_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // a_value[15:0], b_value[31:16]
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // kernel_value[16:0], zero pad
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // kernel_width[15:0]
    output int          o_errors,
    output int          o_pending
);
    import ecs_pkg::*;

    logic [15:0]      width_q;
    logic [CHI_W-1:0] chi_acc;
    logic [23:0]      kernel_q[$];

    // exp(-x) for x in unsigned Q.16, result in Q0.16
    function automatic logic [16:0] exp_neg(input logic [63:0] x);
        logic [63:0] y, k, f, r, t, acc;
        logic [127:0] p;
        int n;
        if (x >= (64'd32 << 16)) return 17'd0;
        p = x * 128'd6196328019 + (128'd1 << 31);
        y = p[95:32];
        k = y >> 16;
        f = y & 64'hFFFF;
        if (k >= 17) return 17'd0;
        r = (f * 64'd2977044472 + (64'd1 << 15)) >> 16;
        t = 64'h1_0000_0000;
        acc = t;
        for (n = 1; n <= 12; n++) begin
            p = t * r;
            t = p[95:32] / n;
            if (n & 1) acc = acc - t;
            else acc = acc + t;
        end
        return 17'((acc + (64'd1 << (15 + k))) >> (16 + k));
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge i_clk) begin
        logic [63:0] a, b, d, df, tm, w;
        logic [64:0] s;
        logic [23:0] exp_v;
        if (!i_rst_n) begin
            width_q <= 16'd256;
            chi_acc <= '0;
            o_errors <= 0;
            kernel_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) width_q <= i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                a = s_axis_tdata[15:0];
                b = s_axis_tdata[31:16];
                d = a + b;
                s = chi_acc;
                if (d != 0) begin
                    df = (a >= b) ? a - b : b - a;
                    tm = ((df * df) << 8) / d;
                    s = s + tm;
                    if (s > SUM_MAX) s = SUM_MAX;
                end
                if (s_axis_tlast) begin
                    w = (width_q == 0) ? 64'd1 : width_q;
                    kernel_q.push_back({7'd0, exp_neg((64'(s[47:0]) << 8) / w)});
                    chi_acc <= '0;
                end else begin
                    chi_acc <= s[47:0];
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (kernel_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = kernel_q.pop_front();
                    if (exp_v !== m_axis_tdata) begin
                        $display("%0t: kernel_value mismatch, expected %0d, actual %0d",
                                 $time, exp_v, m_axis_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = kernel_q.size();
endmodule

[tb/testbench.sv]
// testbench top: stimulus for the exponential chi-squared kernel and verdict
`timescale 1ns / 1ps

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 0;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          calm = 0;

    always #4 i_clk = ~i_clk;

    exp_chi_squared_kernel_core uut (.*);
    kernel_checker chk (.*, .o_errors(errors), .o_pending(pending));

    // watchdog on cycles with no accepted request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (calm) m_axis_tready <= 1;
        else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 0;
            stall = $urandom_range(1, 9);
            repeat (stall - 1) @(posedge i_clk);
        end else m_axis_tready <= 1;
    end

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input bit lst);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {b, a};
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_and_write(input logic [15:0] w);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n, len;
        logic [15:0] widths[6];
        widths = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero pairs, extremes, underflow to zero, zero width
        send_pair(0, 0, 1);
        send_pair(16'hFFFF, 0, 0);
        send_pair(0, 16'hFFFF, 1);
        send_pair(16'h0100, 16'h0100, 1);
        send_pair(16'h0001, 16'h0000, 1);
        send_pair(16'h0010, 16'h0020, 0);
        send_pair(0, 0, 0);
        send_pair(16'h0003, 16'h0001, 1);
        for (int i = 0; i < 6; i++) send_pair(16'hFFFF, 16'h0000, i == 5);
        drain_and_write(16'hFFFF);
        send_pair(16'h0800, 16'h0000, 1);
        send_pair(16'h2000, 16'h0000, 1);
        send_pair(16'hFFFF, 16'h0001, 1);
        drain_and_write(16'd0);
        send_pair(16'h0000, 16'h0001, 1);
        send_pair(16'hAAAA, 16'h5555, 1);

        // random vectors, several width settings
        n = 0;
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(ph == 5 ? 16'($urandom_range(1, 65535)) : widths[ph]);
            if (ph == 5) calm = 1;
            while (n < (ph + 1) * 325) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 6);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(0, 2) == 0)
                        send_pair(rand_val(), rand_val(), j == len - 1);
                    else
                        send_pair(16'($urandom_range(0, 1024)),
                                  16'($urandom_range(0, 1024)), j == len - 1);
                    n++;
                end
            end
        end
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
